@@ hw/rtl/tre_pkg.sv @@
// ----------------------------------------------------------------------------
// tre_pkg: shared types and constants of the texture residency evictor.
// Holds the input and result word layouts and the operation codes.
// ----------------------------------------------------------------------------
package tre_pkg;

  localparam int ENTRIES = 16;
  localparam int HW      = 4;   // handle width, log2 of ENTRIES
  localparam int CW      = 5;   // width of counts that can reach ENTRIES

  localparam logic [2:0] FUNC_BEGIN = 3'd0;
  localparam logic [2:0] FUNC_ADD   = 3'd1;
  localparam logic [2:0] FUNC_TOUCH = 3'd2;
  localparam logic [2:0] FUNC_PUMP  = 3'd3;
  localparam logic [2:0] FUNC_EVICT = 3'd4;

  localparam logic [1:0] KIND_DONE    = 2'd0;
  localparam logic [1:0] KIND_LOADED  = 2'd1;
  localparam logic [1:0] KIND_EVICTED = 2'd2;
  localparam logic [1:0] KIND_REJECT  = 2'd3;

  localparam logic [1:0] REG_BYTE_BUDGET  = 2'd0;
  localparam logic [1:0] REG_MAX_RESIDENT = 2'd1;
  localparam logic [1:0] REG_FREEZE       = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  handle;
    logic [31:0] frame_index;
    logic [15:0] width;
    logic [15:0] height;
    logic        from_disk;
    logic [4:0]  max_loads;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  out_handle;
    logic        last;
    logic [39:0] used_bytes;
    logic [4:0]  resident_count;
    logic [4:0]  evictions;
  } out_word_t;

endpackage

@@ hw/rtl/tre_mem.sv @@
// ----------------------------------------------------------------------------
// tre_mem: single-port-write, single-port-read synchronous RAM.
// Read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module tre_mem import tre_pkg::*; #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [HW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [HW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/tre_out.sv @@
// ----------------------------------------------------------------------------
// tre_out: result output register.
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module tre_out import tre_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_word_t push_word,
  output logic      can_push,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic      valid_r;
  out_word_t data_r;

  assign can_push  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push && can_push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && can_push) begin
      data_r <= push_word;
    end
  end

endmodule

@@ hw/rtl/texture_residency_lru_evictor_unit.sv @@
// ----------------------------------------------------------------------------
// texture_residency_lru_evictor_unit: LRU residency tracker with byte and
// count budgets.
// ----------------------------------------------------------------------------
// One operation is taken at a time. Pump reloads queued entries and drops
// queue entries that are out of range or already resident. Evict scans the
// table through the frame-stamp and size memories once per eviction, at one
// entry a cycle. Loaded and evicted words are collected and sent after the
// operation ends, one per cycle while the consumer accepts them, then the
// final word.
// ----------------------------------------------------------------------------
module texture_residency_lru_evictor_unit import tre_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_TOUCH, S_TOUCH_UPD, S_PUMP, S_PUMP_UPD,
    S_EV_CHK, S_EV_SCAN, S_EV_TAKE, S_DRAIN, S_FINAL
  } state_t;

  state_t        state_r;
  in_word_t      op_r;
  logic [33:0]   prod_r;
  logic [39:0]   budget_r;
  logic [4:0]    max_res_r;
  logic          freeze_r;
  logic [CW-1:0] count_r;
  logic [ENTRIES-1:0] res_r, pin_r, disk_r, load_r;
  logic [HW-1:0] queue_r [ENTRIES];
  logic [HW-1:0] qhead_r;
  logic [CW-1:0] qcount_r;
  logic [31:0]   frame_r;
  logic [4:0]    evc_r;
  logic [39:0]   used_r;
  logic [CW-1:0] rc_r;
  logic [CW-1:0] loaded_r;
  logic [HW-1:0] hbuf_r [ENTRIES];
  logic [CW-1:0] nres_r;
  logic [HW-1:0] rp_r;
  logic [1:0]    lkind_r;
  logic [1:0]    fkind_r;
  logic [HW-1:0] fhandle_r;
  logic [CW-1:0] scan_r;
  logic          rd_v_r;
  logic [HW-1:0] rd_i_r;
  logic          best_v_r;
  logic [HW-1:0] best_r;
  logic [31:0]   best_lru_r;
  logic [33:0]   best_size_r;

  logic          lru_we;
  logic [HW-1:0] lru_waddr;
  logic [31:0]   lru_wdata;
  logic          size_we;
  logic [HW-1:0] size_waddr;
  logic [HW-1:0] raddr;
  logic [31:0]   lru_rdata;
  logic [33:0]   size_rdata;
  logic          push;
  out_word_t     push_word;
  logic          can_push;

  logic          touch_ok, pump_go, scan_issue, scan_done, over, elig;
  logic [HW-1:0] qh_ent;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign touch_ok  = {1'b0, op_r.handle} < count_r;
  assign qh_ent    = queue_r[qhead_r];
  assign pump_go   = (loaded_r < op_r.max_loads) && (qcount_r != '0);
  assign scan_issue = (state_r == S_EV_SCAN) && (scan_r < count_r);
  assign scan_done = (scan_r >= count_r) && !rd_v_r;
  assign over = ((budget_r != '0) && (used_r > budget_r)) ||
                ((max_res_r != '0) && (rc_r > max_res_r));
  assign elig = rd_v_r && res_r[rd_i_r] && !pin_r[rd_i_r] && disk_r[rd_i_r];

  always_comb begin
    lru_we     = 1'b0;
    lru_waddr  = op_r.handle;
    lru_wdata  = frame_r;
    size_we    = 1'b0;
    size_waddr = count_r[HW-1:0];
    raddr      = op_r.handle;
    case (state_r)
      S_ADD: begin
        lru_we    = (count_r < CW'(ENTRIES));
        lru_waddr = count_r[HW-1:0];
        size_we   = lru_we;
      end
      S_TOUCH: begin
        lru_we = touch_ok;
      end
      S_PUMP: begin
        raddr     = qh_ent;
        lru_waddr = qh_ent;
        lru_we    = pump_go && ({1'b0, qh_ent} < count_r) && !res_r[qh_ent];
      end
      S_EV_SCAN: begin
        raddr = scan_r[HW-1:0];
      end
      S_EV_TAKE: begin
        lru_we    = best_v_r;
        lru_waddr = best_r;
        lru_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    push      = 1'b0;
    push_word = '0;
    push_word.resident_count = rc_r;
    push_word.evictions      = evc_r;
    case (state_r)
      S_DRAIN: begin
        push = (nres_r != '0);
        push_word.kind       = lkind_r;
        push_word.out_handle = hbuf_r[rp_r];
      end
      S_FINAL: begin
        push = 1'b1;
        push_word.kind       = fkind_r;
        push_word.out_handle = fhandle_r;
        push_word.last       = 1'b1;
        push_word.used_bytes = used_r;
      end
      default: begin
      end
    endcase
  end

  tre_mem #(.DW(32)) u_lru_mem (
    .clk(clk), .we(lru_we), .waddr(lru_waddr), .wdata(lru_wdata),
    .raddr(raddr), .rdata(lru_rdata)
  );

  tre_mem #(.DW(34)) u_size_mem (
    .clk(clk), .we(size_we), .waddr(size_waddr), .wdata(prod_r),
    .raddr(raddr), .rdata(size_rdata)
  );

  tre_out u_out (
    .clk(clk), .rst_n(rst_n), .push(push), .push_word(push_word),
    .can_push(can_push), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      budget_r  <= '0;
      max_res_r <= '0;
      freeze_r  <= 1'b0;
      count_r   <= '0;
      res_r     <= '0;
      pin_r     <= '0;
      disk_r    <= '0;
      load_r    <= '0;
      qhead_r   <= '0;
      qcount_r  <= '0;
      frame_r   <= '0;
      evc_r     <= '0;
      used_r    <= '0;
      rc_r      <= '0;
      nres_r    <= '0;
      rp_r      <= '0;
      rd_v_r    <= 1'b0;
      best_v_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_BYTE_BUDGET:  budget_r  <= cfg_data;
          REG_MAX_RESIDENT: max_res_r <= cfg_data[4:0];
          REG_FREEZE:       freeze_r  <= cfg_data[0];
          default: begin
          end
        endcase
      end
      rd_v_r <= scan_issue;
      rd_i_r <= scan_r[HW-1:0];
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r      <= in_data;
            prod_r    <= {32'(in_data.width) * 32'(in_data.height), 2'b00};
            fkind_r   <= KIND_DONE;
            fhandle_r <= '0;
            loaded_r  <= '0;
            nres_r    <= '0;
            rp_r      <= '0;
            case (in_data.func)
              FUNC_BEGIN: begin
                frame_r <= in_data.frame_index;
                evc_r   <= '0;
                state_r <= S_FINAL;
              end
              FUNC_ADD:   state_r <= S_ADD;
              FUNC_TOUCH: state_r <= S_TOUCH;
              FUNC_PUMP: begin
                lkind_r <= KIND_LOADED;
                state_r <= S_PUMP;
              end
              FUNC_EVICT: begin
                lkind_r <= KIND_EVICTED;
                state_r <= freeze_r ? S_FINAL : S_EV_CHK;
              end
              default:    state_r <= S_FINAL;
            endcase
          end
        end
        S_ADD: begin
          if (count_r < CW'(ENTRIES)) begin
            res_r[count_r[HW-1:0]]  <= 1'b1;
            pin_r[count_r[HW-1:0]]  <= !op_r.from_disk;
            disk_r[count_r[HW-1:0]] <= op_r.from_disk;
            load_r[count_r[HW-1:0]] <= 1'b0;
            used_r    <= used_r + 40'(prod_r);
            rc_r      <= rc_r + 1'b1;
            count_r   <= count_r + 1'b1;
            fhandle_r <= count_r[HW-1:0];
          end else begin
            fkind_r <= KIND_REJECT;
          end
          state_r <= S_FINAL;
        end
        S_TOUCH: begin
          fhandle_r <= op_r.handle;
          state_r   <= S_FINAL;
          if (touch_ok && !res_r[op_r.handle] && !load_r[op_r.handle]) begin
            if (!disk_r[op_r.handle]) begin
              res_r[op_r.handle] <= 1'b1;
              pin_r[op_r.handle] <= 1'b1;
              state_r <= S_TOUCH_UPD;
            end else if (qcount_r < CW'(ENTRIES)) begin
              load_r[op_r.handle] <= 1'b1;
              queue_r[qhead_r + qcount_r[HW-1:0]] <= op_r.handle;
              qcount_r <= qcount_r + 1'b1;
            end
          end
        end
        S_TOUCH_UPD: begin
          used_r  <= used_r + 40'(size_rdata);
          rc_r    <= rc_r + 1'b1;
          state_r <= S_FINAL;
        end
        S_PUMP: begin
          if (!pump_go) begin
            state_r <= S_DRAIN;
          end else begin
            qhead_r  <= qhead_r + 1'b1;
            qcount_r <= qcount_r - 1'b1;
            if ({1'b0, qh_ent} < count_r) begin
              load_r[qh_ent] <= 1'b0;
              if (!res_r[qh_ent]) begin
                res_r[qh_ent] <= 1'b1;
                hbuf_r[nres_r[HW-1:0]] <= qh_ent;
                state_r <= S_PUMP_UPD;
              end
            end
          end
        end
        S_PUMP_UPD: begin
          used_r   <= used_r + 40'(size_rdata);
          rc_r     <= rc_r + 1'b1;
          nres_r   <= nres_r + 1'b1;
          loaded_r <= loaded_r + 1'b1;
          state_r  <= S_PUMP;
        end
        S_EV_CHK: begin
          scan_r   <= '0;
          best_v_r <= 1'b0;
          state_r  <= over ? S_EV_SCAN : S_DRAIN;
        end
        S_EV_SCAN: begin
          if (scan_issue) begin
            scan_r <= scan_r + 1'b1;
          end
          // Strict compare keeps the lower handle on equal frames.
          if (elig && (!best_v_r || lru_rdata < best_lru_r)) begin
            best_v_r    <= 1'b1;
            best_r      <= rd_i_r;
            best_lru_r  <= lru_rdata;
            best_size_r <= size_rdata;
          end
          if (scan_done) begin
            state_r <= S_EV_TAKE;
          end
        end
        S_EV_TAKE: begin
          if (best_v_r) begin
            res_r[best_r]  <= 1'b0;
            load_r[best_r] <= 1'b0;
            used_r <= (used_r > 40'(best_size_r)) ? used_r - 40'(best_size_r) : '0;
            if (rc_r != '0) begin
              rc_r <= rc_r - 1'b1;
            end
            if (evc_r != 5'd31) begin
              evc_r <= evc_r + 1'b1;
            end
            hbuf_r[nres_r[HW-1:0]] <= best_r;
            nres_r  <= nres_r + 1'b1;
            state_r <= S_EV_CHK;
          end else begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (nres_r == '0) begin
            state_r <= S_FINAL;
          end else if (can_push) begin
            rp_r <= rp_r + 1'b1;
            if ({1'b0, rp_r} + 1'b1 == nres_r) begin
              state_r <= S_FINAL;
            end
          end
        end
        S_FINAL: begin
          if (can_push) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_rc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rc_r <= count_r)
    else $error("resident count above entry count");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcount_r <= CW'(ENTRIES))
    else $error("load queue overflow");

  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EV_SCAN) |-> !lru_we && !size_we)
    else $error("memory write during eviction scan");

  a_push_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINAL && can_push) |=> (state_r == S_IDLE))
    else $error("final word sent without returning to idle");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the texture residency LRU evictor.
// Random and directed operations go in, every result word is checked against
// a predictor of the table, its load queue and its two budgets.
// ----------------------------------------------------------------------------
module tb_top;
  import tre_pkg::*;

  class residency_scoreboard;
    logic [39:0] byte_budget;
    logic [4:0]  max_resident;
    logic        freeze;
    logic [4:0]  entry_count;
    logic        resident[ENTRIES];
    logic        pinned[ENTRIES];
    logic        on_disk[ENTRIES];
    logic        loading[ENTRIES];
    logic [31:0] stamp[ENTRIES];
    logic [33:0] size_bytes[ENTRIES];
    logic [3:0]  load_q[ENTRIES];
    logic [3:0]  q_head;
    logic [4:0]  q_count;
    logic [31:0] cur_frame;
    logic [4:0]  evict_count;
    out_word_t   awaited[$];
    int          mismatches;
    int          words_checked;
    int          loads_seen;
    int          evictions_seen;
    int          rejects_seen;

    function new();
      byte_budget = '0;
      max_resident = '0;
      freeze = 1'b0;
      entry_count = '0;
      q_head = '0;
      q_count = '0;
      cur_frame = '0;
      evict_count = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        resident[i] = 0;
        pinned[i] = 0;
        on_disk[i] = 0;
        loading[i] = 0;
        stamp[i] = '0;
        size_bytes[i] = '0;
        load_q[i] = '0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [39:0] value);
      case (idx)
        REG_BYTE_BUDGET:  byte_budget = value;
        REG_MAX_RESIDENT: max_resident = value[4:0];
        REG_FREEZE:       freeze = value[0];
        default: ;
      endcase
    endfunction

    function void tally(output logic [39:0] bytes, output logic [4:0] count);
      bytes = '0;
      count = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (i < entry_count && resident[i]) begin
          bytes += 40'(size_bytes[i]);
          count++;
        end
      end
    endfunction

    function bit over(logic [39:0] bytes, logic [4:0] count);
      return (byte_budget != 0 && bytes > byte_budget) ||
             (max_resident != 0 && count > max_resident);
    endfunction

    function void note_input(in_word_t w);
      logic [1:0]  kinds[$];
      logic [3:0]  handles[$];
      logic [1:0]  fin_kind;
      logic [3:0]  fin_handle;
      logic [39:0] used;
      logic [4:0]  rc;
      logic [3:0]  e;
      logic        taken[ENTRIES];
      int          loaded;
      int          best;
      out_word_t   o;
      fin_kind = KIND_DONE;
      fin_handle = '0;
      case (w.func)
        FUNC_BEGIN: begin
          cur_frame = w.frame_index;
          evict_count = '0;
        end
        FUNC_ADD: begin
          if (entry_count >= ENTRIES) begin
            fin_kind = KIND_REJECT;
          end else begin
            e = entry_count[3:0];
            resident[e] = 1;
            pinned[e] = !w.from_disk;
            on_disk[e] = w.from_disk;
            loading[e] = 0;
            stamp[e] = cur_frame;
            size_bytes[e] = 34'(w.width) * 34'(w.height) * 34'd4;
            entry_count++;
            fin_handle = e;
          end
        end
        FUNC_TOUCH: begin
          fin_handle = w.handle;
          if (w.handle < entry_count) begin
            stamp[w.handle] = cur_frame;
            if (!resident[w.handle] && !loading[w.handle]) begin
              if (!on_disk[w.handle]) begin
                resident[w.handle] = 1;
                pinned[w.handle] = 1;
              end else if (q_count < ENTRIES) begin
                loading[w.handle] = 1;
                load_q[4'(q_head + q_count)] = w.handle;
                q_count++;
              end
            end
          end
        end
        FUNC_PUMP: begin
          loaded = 0;
          while (loaded < w.max_loads && q_count > 0) begin
            e = load_q[q_head];
            q_head++;
            q_count--;
            if (e >= entry_count) continue;
            loading[e] = 0;
            if (resident[e]) continue;
            resident[e] = 1;
            stamp[e] = cur_frame;
            kinds.insert(kinds.size(), KIND_LOADED);
            handles.insert(handles.size(), e);
            loaded++;
          end
        end
        FUNC_EVICT: begin
          if (!freeze) begin
            tally(used, rc);
            for (int i = 0; i < ENTRIES; i++) taken[i] = 0;
            while (over(used, rc)) begin
              best = -1;
              for (int i = 0; i < ENTRIES; i++) begin
                if (i >= entry_count || taken[i] || !resident[i] || pinned[i] || !on_disk[i])
                  continue;
                if (best < 0 || stamp[i] < stamp[best]) best = i;
              end
              if (best < 0) break;
              taken[best] = 1;
              resident[best] = 0;
              loading[best] = 0;
              stamp[best] = '0;
              if (rc > 0) rc--;
              used = (used > 40'(size_bytes[best])) ? used - 40'(size_bytes[best]) : '0;
              if (evict_count < 31) evict_count++;
              kinds.insert(kinds.size(), KIND_EVICTED);
              handles.insert(handles.size(), 4'(best));
            end
          end
        end
        default: ;
      endcase
      tally(used, rc);
      foreach (kinds[k]) begin
        o.kind = kinds[k];
        o.out_handle = handles[k];
        o.last = 1'b0;
        o.used_bytes = '0;
        o.resident_count = rc;
        o.evictions = evict_count;
        awaited.insert(awaited.size(), o);
      end
      o.kind = fin_kind;
      o.out_handle = fin_handle;
      o.last = 1'b1;
      o.used_bytes = used;
      o.resident_count = rc;
      o.evictions = evict_count;
      awaited.insert(awaited.size(), o);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result word %h", got);
        return;
      end
      want = awaited[0];
      awaited.delete(0);
      words_checked++;
      if (got.kind == KIND_LOADED) loads_seen++;
      if (got.kind == KIND_EVICTED) evictions_seen++;
      if (got.kind == KIND_REJECT) rejects_seen++;
      if (got.kind !== want.kind || got.out_handle !== want.out_handle ||
          got.last !== want.last || got.used_bytes !== want.used_bytes ||
          got.resident_count !== want.resident_count ||
          got.evictions !== want.evictions) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: result %0d: expected kind %0d handle %0d last %0b ",
                    "bytes %0d count %0d evictions %0d, got kind %0d handle %0d ",
                    "last %0b bytes %0d count %0d evictions %0d"},
                   words_checked, want.kind, want.out_handle, want.last, want.used_bytes,
                   want.resident_count, want.evictions, got.kind, got.out_handle, got.last,
                   got.used_bytes, got.resident_count, got.evictions);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [39:0] cfg_data;

  residency_scoreboard sb;
  bit  no_idle;
  bit  hold_req;
  int  ops_sent;
  int  cycles = 0;

  texture_residency_lru_evictor_unit dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Consumer: random stalls, plus one long hold-off so the block backs up.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_op(in_word_t w);
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
    ops_sent++;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [39:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic in_word_t make_op(logic [2:0] f);
    in_word_t w;
    w.func = f;
    w.handle = 4'($urandom_range(0, 15));
    w.frame_index = $urandom();
    if ($urandom_range(0, 9) == 0) begin
      w.width = 16'($urandom());
      w.height = 16'($urandom());
    end else begin
      w.width = 16'($urandom_range(0, 64));
      w.height = 16'($urandom_range(0, 64));
    end
    w.from_disk = ($urandom_range(0, 4) != 0);
    w.max_loads = ($urandom_range(0, 3) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 4));
    return w;
  endfunction

  function automatic in_word_t random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return make_op(FUNC_BEGIN);
    if (r < 20) return make_op(FUNC_ADD);
    if (r < 55) return make_op(FUNC_TOUCH);
    if (r < 72) return make_op(FUNC_PUMP);
    if (r < 97) return make_op(FUNC_EVICT);
    return make_op(3'($urandom_range(5, 7)));
  endfunction

  initial begin
    in_word_t w;
    logic [39:0] budgets[6];
    logic [4:0]  limits[6];
    sb = new();
    no_idle = 0;
    hold_req = 0;
    ops_sent = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_BYTE_BUDGET;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: size extremes, pinned entries, unknown handles, empty pumps.
    w = make_op(FUNC_ADD);
    w.width = 16'hFFFF; w.height = 16'hFFFF; w.from_disk = 1'b1; send_op(w);
    w.width = 16'd0; w.height = 16'd0; w.from_disk = 1'b0; send_op(w);
    w.width = 16'd100; w.height = 16'd3; w.from_disk = 1'b1; send_op(w);
    w = make_op(FUNC_BEGIN); w.frame_index = 32'hFFFF_FFFF; send_op(w);
    w = make_op(FUNC_TOUCH); w.handle = 4'd0; send_op(w);
    w.handle = 4'd15; send_op(w);
    w = make_op(FUNC_PUMP); w.max_loads = 5'd0; send_op(w);
    w.max_loads = 5'd31; send_op(w);
    send_op(make_op(FUNC_EVICT));
    for (int f = 5; f < 8; f++) send_op(make_op(3'(f)));
    w = make_op(FUNC_BEGIN); w.frame_index = 32'd0; send_op(w);
    drain();

    // Tight byte budget evicts everything evictable, then the directed
    // entries come back through touch and pump.
    write_cfg(REG_BYTE_BUDGET, 40'd1);
    write_cfg(REG_MAX_RESIDENT, 40'd1);
    write_cfg(REG_FREEZE, 40'd1);
    send_op(make_op(FUNC_EVICT));
    drain();
    write_cfg(REG_FREEZE, 40'd0);
    send_op(make_op(FUNC_EVICT));
    w = make_op(FUNC_TOUCH); w.handle = 4'd0; send_op(w);
    w.handle = 4'd2; send_op(w);
    w.handle = 4'd0; send_op(w);
    w = make_op(FUNC_PUMP); w.max_loads = 5'd16; send_op(w);
    drain();

    budgets = '{40'd20000, 40'hFF_FFFF_FFFF, 40'd0, 40'd5000, 40'd60000, 40'd9000};
    limits = '{5'd0, 5'd16, 5'd3, 5'd0, 5'd8, 5'd1};
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(REG_BYTE_BUDGET, budgets[ph]);
      write_cfg(REG_MAX_RESIDENT, 40'(limits[ph]));
      write_cfg(REG_FREEZE, 40'(ph == 3));
      no_idle = (ph == 5);
      if (ph == 2) hold_req = 1;
      repeat (57) send_op(random_op());
      drain();
    end

    $display("Ran %0d operations over several budget settings: %0d words checked,",
             ops_sent, sb.words_checked);
    $display("%0d reloads, %0d evictions, %0d rejected adds, %0d mismatches.",
             sb.loads_seen, sb.evictions_seen, sb.rejects_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/tre_pkg.sv
hw/rtl/tre_mem.sv
hw/rtl/tre_out.sv
hw/rtl/texture_residency_lru_evictor_unit.sv
sim/tb_top.sv
